/* hdl/alist_pkg.sv */
package alist_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned FOUND_W  = 7;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CMD_W    = 3;

	localparam logic [DATA_W-1:0]  WORD_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [FOUND_W-1:0] FOUND_NONE = {FOUND_W{1'b1}};

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_GET    = 3'd3,
		CMD_SET    = 3'd4,
		CMD_INDEX  = 3'd5,
		CMD_CLEAR  = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_INS_CHK,
		S_INS_WR,
		S_REM_CHK,
		S_REM_WR,
		S_GET_WAIT,
		S_SCAN_CHK,
		S_SCAN_CMP
	} state_t;

	typedef enum logic [2:0] {
		PTR_KEEP,
		PTR_COUNT,
		PTR_POS,
		PTR_ZERO,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	typedef enum logic [1:0] {
		RA_PTR,
		RA_PTR_M1,
		RA_PTR_P1,
		RA_POS
	} raddr_sel_t;

	typedef enum logic [1:0] {
		WA_PTR,
		WA_COUNT,
		WA_POS
	} waddr_sel_t;

	typedef enum logic {
		WD_DATA,
		WD_RDATA
	} wdata_sel_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef enum logic [1:0] {
		RV_ZERO,
		RV_MIN,
		RV_RDATA
	} rd_sel_t;

	typedef enum logic [1:0] {
		FI_ZERO,
		FI_NONE,
		FI_PTR
	} found_sel_t;

	typedef struct packed {
		logic       take;
		ptr_op_t    ptr_op;
		logic       rd_en;
		raddr_sel_t raddr_sel;
		logic       wr_en;
		waddr_sel_t waddr_sel;
		wdata_sel_t wdata_sel;
		cnt_op_t    cnt_op;
		logic       res_load;
		status_t    res_status;
		rd_sel_t    res_rd_sel;
		found_sel_t res_found_sel;
	} ctl_t;

	typedef struct packed {
		logic in_range;
		logic full;
		logic ins_more;
		logic rem_more;
		logic scan_more;
		logic match;
		logic res_busy;
	} stat_t;

endpackage

/* hdl/alist_ctrl.sv */
module alist_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [alist_pkg::CMD_W-1:0]    in_cmd,
	input  alist_pkg::stat_t               stat,
	output alist_pkg::ctl_t                ctl
);

	alist_pkg::state_t state_q, state_d;
	alist_pkg::cmd_t   cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alist_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q <= alist_pkg::cmd_t'(in_cmd);
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			alist_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.take = 1'b1;
					state_d  = alist_pkg::S_EXEC;
				end
			end
			alist_pkg::S_EXEC: begin
				case (cmd_q)
					alist_pkg::CMD_APPEND: begin
						if (!stat.res_busy) begin
							ctl.res_load = 1'b1;
							state_d      = alist_pkg::S_IDLE;
							if (stat.full) begin
								ctl.res_status = alist_pkg::ST_FULL;
							end else begin
								ctl.wr_en     = 1'b1;
								ctl.waddr_sel = alist_pkg::WA_COUNT;
								ctl.wdata_sel = alist_pkg::WD_DATA;
								ctl.cnt_op    = alist_pkg::CNT_INC;
							end
						end
					end
					alist_pkg::CMD_INSERT: begin
						if (!stat.in_range || stat.full) begin
							if (!stat.res_busy) begin
								ctl.res_load   = 1'b1;
								ctl.res_status = stat.in_range ? alist_pkg::ST_FULL
									: alist_pkg::ST_RANGE;
								state_d        = alist_pkg::S_IDLE;
							end
						end else begin
							ctl.ptr_op = alist_pkg::PTR_COUNT;
							state_d    = alist_pkg::S_INS_CHK;
						end
					end
					alist_pkg::CMD_REMOVE: begin
						if (!stat.in_range) begin
							if (!stat.res_busy) begin
								ctl.res_load   = 1'b1;
								ctl.res_status = alist_pkg::ST_RANGE;
								state_d        = alist_pkg::S_IDLE;
							end
						end else begin
							ctl.ptr_op = alist_pkg::PTR_POS;
							state_d    = alist_pkg::S_REM_CHK;
						end
					end
					alist_pkg::CMD_GET: begin
						if (!stat.in_range) begin
							if (!stat.res_busy) begin
								ctl.res_load   = 1'b1;
								ctl.res_status = alist_pkg::ST_RANGE;
								ctl.res_rd_sel = alist_pkg::RV_MIN;
								state_d        = alist_pkg::S_IDLE;
							end
						end else begin
							ctl.rd_en     = 1'b1;
							ctl.raddr_sel = alist_pkg::RA_POS;
							state_d       = alist_pkg::S_GET_WAIT;
						end
					end
					alist_pkg::CMD_SET: begin
						if (!stat.res_busy) begin
							ctl.res_load = 1'b1;
							state_d      = alist_pkg::S_IDLE;
							if (!stat.in_range) begin
								ctl.res_status = alist_pkg::ST_RANGE;
							end else begin
								ctl.wr_en     = 1'b1;
								ctl.waddr_sel = alist_pkg::WA_POS;
								ctl.wdata_sel = alist_pkg::WD_DATA;
							end
						end
					end
					alist_pkg::CMD_INDEX: begin
						ctl.ptr_op = alist_pkg::PTR_ZERO;
						state_d    = alist_pkg::S_SCAN_CHK;
					end
					alist_pkg::CMD_CLEAR: begin
						if (!stat.res_busy) begin
							ctl.res_load = 1'b1;
							ctl.cnt_op   = alist_pkg::CNT_CLR;
							state_d      = alist_pkg::S_IDLE;
						end
					end
					default: begin
						if (!stat.res_busy) begin
							ctl.res_load = 1'b1;
							state_d      = alist_pkg::S_IDLE;
						end
					end
				endcase
			end
			// move entries up from the top, then drop the new word into the gap
			alist_pkg::S_INS_CHK: begin
				if (stat.ins_more) begin
					ctl.rd_en     = 1'b1;
					ctl.raddr_sel = alist_pkg::RA_PTR_M1;
					state_d       = alist_pkg::S_INS_WR;
				end else if (!stat.res_busy) begin
					ctl.wr_en     = 1'b1;
					ctl.waddr_sel = alist_pkg::WA_POS;
					ctl.wdata_sel = alist_pkg::WD_DATA;
					ctl.cnt_op    = alist_pkg::CNT_INC;
					ctl.res_load  = 1'b1;
					state_d       = alist_pkg::S_IDLE;
				end
			end
			alist_pkg::S_INS_WR: begin
				ctl.wr_en     = 1'b1;
				ctl.waddr_sel = alist_pkg::WA_PTR;
				ctl.wdata_sel = alist_pkg::WD_RDATA;
				ctl.ptr_op    = alist_pkg::PTR_DEC;
				state_d       = alist_pkg::S_INS_CHK;
			end
			alist_pkg::S_REM_CHK: begin
				if (stat.rem_more) begin
					ctl.rd_en     = 1'b1;
					ctl.raddr_sel = alist_pkg::RA_PTR_P1;
					state_d       = alist_pkg::S_REM_WR;
				end else if (!stat.res_busy) begin
					ctl.cnt_op   = alist_pkg::CNT_DEC;
					ctl.res_load = 1'b1;
					state_d      = alist_pkg::S_IDLE;
				end
			end
			alist_pkg::S_REM_WR: begin
				ctl.wr_en     = 1'b1;
				ctl.waddr_sel = alist_pkg::WA_PTR;
				ctl.wdata_sel = alist_pkg::WD_RDATA;
				ctl.ptr_op    = alist_pkg::PTR_INC;
				state_d       = alist_pkg::S_REM_CHK;
			end
			alist_pkg::S_GET_WAIT: begin
				if (!stat.res_busy) begin
					ctl.res_load   = 1'b1;
					ctl.res_rd_sel = alist_pkg::RV_RDATA;
					state_d        = alist_pkg::S_IDLE;
				end
			end
			alist_pkg::S_SCAN_CHK: begin
				if (stat.scan_more) begin
					ctl.rd_en     = 1'b1;
					ctl.raddr_sel = alist_pkg::RA_PTR;
					state_d       = alist_pkg::S_SCAN_CMP;
				end else if (!stat.res_busy) begin
					ctl.res_load      = 1'b1;
					ctl.res_found_sel = alist_pkg::FI_NONE;
					state_d           = alist_pkg::S_IDLE;
				end
			end
			alist_pkg::S_SCAN_CMP: begin
				if (!stat.match) begin
					ctl.ptr_op = alist_pkg::PTR_INC;
					state_d    = alist_pkg::S_SCAN_CHK;
				end else if (!stat.res_busy) begin
					ctl.res_load      = 1'b1;
					ctl.res_found_sel = alist_pkg::FI_PTR;
					state_d           = alist_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = alist_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/alist_dp.sv */
module alist_dp #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [alist_pkg::DATA_W-1:0]      in_data,
	input  logic [alist_pkg::POS_W-1:0]       in_pos,
	input  alist_pkg::ctl_t                   ctl,
	output alist_pkg::stat_t                  stat,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic signed [alist_pkg::DATA_W-1:0]  res_value,
	output logic signed [alist_pkg::FOUND_W-1:0] res_found,
	output logic [alist_pkg::STATUS_W-1:0]    res_status,
	output logic [alist_pkg::COUNT_W-1:0]     res_count
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = CW + alist_pkg::POS_W + alist_pkg::FOUND_W;

	logic [alist_pkg::DATA_W-1:0] mem [CAPACITY];
	logic [alist_pkg::DATA_W-1:0] rdata_q;
	logic [alist_pkg::DATA_W-1:0] data_q;
	logic [alist_pkg::POS_W-1:0]  pos_q;
	logic [CW-1:0]                count_q, count_d;
	logic [CW-1:0]                ptr_q, ptr_m1, ptr_p1;
	logic [XW-1:0]                pos_x, count_x, ptr_x, count_dx;
	logic [AW-1:0]                raddr, waddr;
	logic [alist_pkg::DATA_W-1:0] wdata;
	logic                         valid_q;

	assign pos_x    = XW'(pos_q);
	assign count_x  = XW'(count_q);
	assign ptr_x    = XW'(ptr_q);
	assign count_dx = XW'(count_d);
	assign ptr_m1   = ptr_q - 1'b1;
	assign ptr_p1   = ptr_q + 1'b1;

	assign stat.in_range  = pos_x < count_x;
	assign stat.full      = count_q == CW'(CAPACITY);
	assign stat.ins_more  = ptr_x > pos_x;
	assign stat.rem_more  = (ptr_x + 1'b1) < count_x;
	assign stat.scan_more = ptr_q < count_q;
	assign stat.match     = rdata_q == data_q;
	assign stat.res_busy  = valid_q && !res_ready;

	always_comb begin
		unique case (ctl.raddr_sel)
			alist_pkg::RA_PTR_M1: raddr = ptr_m1[AW-1:0];
			alist_pkg::RA_PTR_P1: raddr = ptr_p1[AW-1:0];
			alist_pkg::RA_POS:    raddr = pos_x[AW-1:0];
			default:              raddr = ptr_q[AW-1:0];
		endcase
		unique case (ctl.waddr_sel)
			alist_pkg::WA_COUNT: waddr = count_q[AW-1:0];
			alist_pkg::WA_POS:   waddr = pos_x[AW-1:0];
			default:             waddr = ptr_q[AW-1:0];
		endcase
		wdata = (ctl.wdata_sel == alist_pkg::WD_RDATA) ? rdata_q : data_q;
		unique case (ctl.cnt_op)
			alist_pkg::CNT_INC: count_d = count_q + 1'b1;
			alist_pkg::CNT_DEC: count_d = count_q - 1'b1;
			alist_pkg::CNT_CLR: count_d = '0;
			default:            count_d = count_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			data_q <= in_data;
			pos_q  <= in_pos;
		end
		case (ctl.ptr_op)
			alist_pkg::PTR_COUNT: ptr_q <= count_q;
			alist_pkg::PTR_POS:   ptr_q <= pos_x[CW-1:0];
			alist_pkg::PTR_ZERO:  ptr_q <= '0;
			alist_pkg::PTR_INC:   ptr_q <= ptr_p1;
			alist_pkg::PTR_DEC:   ptr_q <= ptr_m1;
			default:              ptr_q <= ptr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (ctl.res_load) begin
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result register: count reported is the value after this request
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			res_status <= ctl.res_status;
			res_count  <= count_dx[alist_pkg::COUNT_W-1:0];
			case (ctl.res_rd_sel)
				alist_pkg::RV_MIN:   res_value <= alist_pkg::WORD_MIN;
				alist_pkg::RV_RDATA: res_value <= rdata_q;
				default:             res_value <= '0;
			endcase
			case (ctl.res_found_sel)
				alist_pkg::FI_NONE: res_found <= alist_pkg::FOUND_NONE;
				alist_pkg::FI_PTR:  res_found <= ptr_x[alist_pkg::FOUND_W-1:0];
				default:            res_found <= '0;
			endcase
		end
	end

	assign res_valid = valid_q;

endmodule

/* hdl/array_list_engine_top.sv */
// Array list engine: an ordered list of signed 32-bit words held in an internal
// memory of CAPACITY entries.
// Requests arrive on the s_ channel: s_tuser carries the command (append,
// insert at, remove at, get, set, index of, clear), s_tdata the word and the
// position. Each request yields exactly one result on the m_ channel with the
// word read, the matched position, a status code and the element count.
// One request is processed at a time. Append, set, clear, an unused code and an
// out-of-range or full request load the result from the execute state, get after
// a memory read. Insert moves entries from index up one place, top first, then
// writes the word; remove moves entries above index down; index of compares from
// 0 until a match or the list end. Memory is read then written per entry moved
// and read per entry compared. After loading a result the engine returns to idle,
// where it takes the next request; a new request is not taken before then.
// A new request is taken while the previous result still waits in the output
// register; if the receiver stalls, the engine holds its final step until
// that register frees up.
// Reset empties the list and drops any pending result; memory contents are
// left as they are and only entries written since are ever read.
module array_list_engine_top #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // data[31:0], index[37:32], zero[39:38]
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // read_value[31:0], found_index[38:32],
	                              // status[40:39], element_count[47:41]
);

	alist_pkg::ctl_t  ctl;
	alist_pkg::stat_t stat;

	logic signed [alist_pkg::DATA_W-1:0]  read_value;
	logic signed [alist_pkg::FOUND_W-1:0] found_index;
	logic [alist_pkg::STATUS_W-1:0]       status;
	logic [alist_pkg::COUNT_W-1:0]        element_count;

	alist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.stat     (stat),
		.ctl      (ctl)
	);

	alist_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (s_tdata[31:0]),
		.in_pos     (s_tdata[37:32]),
		.ctl        (ctl),
		.stat       (stat),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_value  (read_value),
		.res_found  (found_index),
		.res_status (status),
		.res_count  (element_count)
	);

	assign m_tdata = {element_count, status, found_index, read_value};

endmodule
